/* sv/s2ck_pkg.sv */
// shared types and constants for the spherical to cartesian kinematics core
`timescale 1ns / 1ps

package s2ck_pkg;

    // default geometry of the angle and length formats
    localparam int ANGLE_BITS_DEF = 16;
    localparam int FRAC_BITS_DEF  = 16;

    // trig values are Q2.30
    localparam int TRIG_FRAC = 30;

    localparam logic [30:0] ONE_Q30      = 31'h4000_0000;
    localparam logic [32:0] TWO_PI_Q30   = 33'd6746518852;
    localparam logic [29:0] EIGHTH_TURN  = 30'h2000_0000;
    localparam logic [30:0] QUARTER_TURN = 31'h4000_0000;

    // reciprocals for exact floor division of values below 2^30
    localparam int SH_42 = 36;
    localparam int SH_56 = 36;
    localparam int SH_20 = 35;
    localparam int SH_30 = 35;
    localparam int SH_6  = 33;
    localparam int SH_12 = 34;

    localparam logic [31:0] RECIP_42 = 32'(((64'd1 << SH_42) + 64'd41) / 64'd42);
    localparam logic [31:0] RECIP_56 = 32'(((64'd1 << SH_56) + 64'd55) / 64'd56);
    localparam logic [31:0] RECIP_20 = 32'(((64'd1 << SH_20) + 64'd19) / 64'd20);
    localparam logic [31:0] RECIP_30 = 32'(((64'd1 << SH_30) + 64'd29) / 64'd30);
    localparam logic [31:0] RECIP_6  = 32'(((64'd1 << SH_6) + 64'd5) / 64'd6);
    localparam logic [31:0] RECIP_12 = 32'(((64'd1 << SH_12) + 64'd11) / 64'd12);

    // quadrant codes
    localparam logic [1:0] QUAD_I   = 2'd0;
    localparam logic [1:0] QUAD_II  = 2'd1;
    localparam logic [1:0] QUAD_III = 2'd2;

    // queue between front and back, power of two depth
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    typedef struct packed {
        logic [15:0]        azimuth;
        logic [15:0]        zenith;
        logic signed [31:0] range_len;
        logic signed [31:0] azimuth_rate;
        logic signed [31:0] zenith_rate;
        logic signed [31:0] range_rate;
        logic signed [31:0] azimuth_accel;
        logic signed [31:0] zenith_accel;
        logic signed [31:0] range_accel;
    } s2ck_track_t;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic signed [31:0] vel_z;
        logic signed [31:0] acc_x;
        logic signed [31:0] acc_y;
        logic signed [31:0] acc_z;
    } s2ck_cart_t;

    // angle folded into the first octant
    typedef struct packed {
        logic [29:0] frac;
        logic        swap;
        logic [1:0]  quad;
    } s2ck_oct_t;

    typedef struct packed {
        logic signed [31:0] range_len;
        logic signed [31:0] azimuth_rate;
        logic signed [31:0] zenith_rate;
        logic signed [31:0] range_rate;
        logic signed [31:0] azimuth_accel;
        logic signed [31:0] zenith_accel;
        logic signed [31:0] range_accel;
    } s2ck_rates_t;

    // classified item handed from front to back
    typedef struct packed {
        s2ck_oct_t   az;
        s2ck_oct_t   ze;
        s2ck_rates_t rates;
    } s2ck_work_t;

    typedef struct packed {
        logic signed [31:0] sin_az;
        logic signed [31:0] cos_az;
        logic signed [31:0] sin_ze;
        logic signed [31:0] cos_ze;
    } s2ck_trig_t;

endpackage

/* sv/s2ck_front.sv */
// front stage: accepts track items and folds both angles into an octant
`timescale 1ns / 1ps

module s2ck_front #(
    parameter int ANGLE_BITS = s2ck_pkg::ANGLE_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 track_valid,
    output logic                 track_ready,
    input  s2ck_pkg::s2ck_track_t track,
    output logic                 push_valid,
    input  logic                 push_ready,
    output s2ck_pkg::s2ck_work_t push_data
);

    logic                 fv_reg;
    logic                 fv_next;
    s2ck_pkg::s2ck_work_t work_reg;
    s2ck_pkg::s2ck_work_t work_next;

    // widen to a 32 bit turn, wrap, and fold to the first octant
    function automatic s2ck_pkg::s2ck_oct_t fold(input logic [15:0] ang);
        logic [31:0]        turn;
        logic [29:0]        rem;
        s2ck_pkg::s2ck_oct_t o;
        turn = {16'b0, ang} << (32 - ANGLE_BITS);
        rem  = turn[29:0];
        o.quad = turn[31:30];
        if (rem <= s2ck_pkg::EIGHTH_TURN)
        begin
            o.frac = rem;
            o.swap = 1'b0;
        end
        else
        begin
            o.frac = 30'(s2ck_pkg::QUARTER_TURN - {1'b0, rem});
            o.swap = 1'b1;
        end
        return o;
    endfunction

    // classify the incoming item
    always_comb
    begin
        work_next.az                  = fold(track.azimuth);
        work_next.ze                  = fold(track.zenith);
        work_next.rates.range_len     = track.range_len;
        work_next.rates.azimuth_rate  = track.azimuth_rate;
        work_next.rates.zenith_rate   = track.zenith_rate;
        work_next.rates.range_rate    = track.range_rate;
        work_next.rates.azimuth_accel = track.azimuth_accel;
        work_next.rates.zenith_accel  = track.zenith_accel;
        work_next.rates.range_accel   = track.range_accel;
    end

    // holding register, free when empty or when the queue takes it
    assign track_ready = !fv_reg || push_ready;
    assign push_valid  = fv_reg;
    assign push_data   = work_reg;

    always_comb
    begin
        if (track_valid && track_ready)
            fv_next = 1'b1;
        else if (push_ready)
            fv_next = 1'b0;
        else
            fv_next = fv_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fv_reg <= 1'b0;
        else
            fv_reg <= fv_next;
    end

    always_ff @(posedge clk)
    begin
        if (track_valid && track_ready)
            work_reg <= work_next;
    end

endmodule

/* sv/s2ck_queue.sv */
// short queue between the front and the back
`timescale 1ns / 1ps

module s2ck_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push_valid,
    output logic                 push_ready,
    input  s2ck_pkg::s2ck_work_t push_data,
    output logic                 pop_valid,
    input  logic                 pop_ready,
    output s2ck_pkg::s2ck_work_t pop_data
);

    s2ck_pkg::s2ck_work_t             mem [s2ck_pkg::Q_DEPTH];
    logic [s2ck_pkg::Q_PTR_W-1:0] wr_ptr_reg;
    logic [s2ck_pkg::Q_PTR_W-1:0] wr_ptr_next;
    logic [s2ck_pkg::Q_PTR_W-1:0] rd_ptr_reg;
    logic [s2ck_pkg::Q_PTR_W-1:0] rd_ptr_next;
    logic [s2ck_pkg::Q_CNT_W-1:0] count_reg;
    logic [s2ck_pkg::Q_CNT_W-1:0] count_next;
    logic                         push;
    logic                         pop;

    assign push_ready = (count_reg != s2ck_pkg::Q_CNT_W'(s2ck_pkg::Q_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = mem[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    // pointers wrap naturally at a power of two depth
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_data;
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= s2ck_pkg::Q_CNT_W'(s2ck_pkg::Q_DEPTH))
        else $error("queue count above depth");

    a_count_inc: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> count_reg == $past(count_reg) + 1'b1)
        else $error("queue count missed a push");

    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("queue pointers apart while empty");
`endif

endmodule

/* sv/s2ck_trig.sv */
// pipelined sine and cosine of a folded angle, Q2.30, nine stages
`timescale 1ns / 1ps

module s2ck_trig (
    input  logic                clk,
    input  logic                en,
    input  s2ck_pkg::s2ck_oct_t oct,
    output logic signed [31:0]  sin_q,
    output logic signed [31:0]  cos_q
);

    logic [29:0] x_reg  [1:7];
    logic [29:0] xx_reg [2:7];
    logic [7:0]  swap_reg;
    logic [1:0]  quad_reg [8];
    logic [29:0] qs3_reg, qc3_reg, ps4_reg, pc4_reg;
    logic [29:0] qs5_reg, qc5_reg, ps6_reg, pc6_reg;
    logic [29:0] qs7_reg, qc7_reg, sn8_reg, pc8_reg;
    logic signed [31:0] sin_reg, cos_reg;
    logic [30:0]        cs9;
    logic signed [31:0] s0, c0;

    // final cosine step and octant unfolding
    always_comb
    begin
        cs9 = s2ck_pkg::ONE_Q30 - 31'(pc8_reg[29:1]);
        if (swap_reg[7])
        begin
            s0 = signed'(32'(cs9));
            c0 = signed'(32'(sn8_reg));
        end
        else
        begin
            s0 = signed'(32'(sn8_reg));
            c0 = signed'(32'(cs9));
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // angle to radians and its square
            x_reg[1]  <= 30'((63'(oct.frac) * 63'(s2ck_pkg::TWO_PI_Q30)) >> 32);
            xx_reg[2] <= 30'((60'(x_reg[1]) * 60'(x_reg[1])) >> s2ck_pkg::TRIG_FRAC);
            for (int i = 2; i <= 7; i++)
                x_reg[i] <= x_reg[i-1];
            for (int i = 3; i <= 7; i++)
                xx_reg[i] <= xx_reg[i-1];
            swap_reg    <= {swap_reg[6:0], oct.swap};
            quad_reg[0] <= oct.quad;
            for (int i = 1; i < 8; i++)
                quad_reg[i] <= quad_reg[i-1];

            // horner step one
            qs3_reg <= 30'((62'(xx_reg[2]) * 62'(s2ck_pkg::RECIP_42)) >> s2ck_pkg::SH_42);
            qc3_reg <= 30'((62'(xx_reg[2]) * 62'(s2ck_pkg::RECIP_56)) >> s2ck_pkg::SH_56);
            ps4_reg <= 30'((61'(xx_reg[3]) * 61'(s2ck_pkg::ONE_Q30 - 31'(qs3_reg)))
                           >> s2ck_pkg::TRIG_FRAC);
            pc4_reg <= 30'((61'(xx_reg[3]) * 61'(s2ck_pkg::ONE_Q30 - 31'(qc3_reg)))
                           >> s2ck_pkg::TRIG_FRAC);

            // horner step two
            qs5_reg <= 30'((62'(ps4_reg) * 62'(s2ck_pkg::RECIP_20)) >> s2ck_pkg::SH_20);
            qc5_reg <= 30'((62'(pc4_reg) * 62'(s2ck_pkg::RECIP_30)) >> s2ck_pkg::SH_30);
            ps6_reg <= 30'((61'(xx_reg[5]) * 61'(s2ck_pkg::ONE_Q30 - 31'(qs5_reg)))
                           >> s2ck_pkg::TRIG_FRAC);
            pc6_reg <= 30'((61'(xx_reg[5]) * 61'(s2ck_pkg::ONE_Q30 - 31'(qc5_reg)))
                           >> s2ck_pkg::TRIG_FRAC);

            // horner step three, sine closes with x
            qs7_reg <= 30'((62'(ps6_reg) * 62'(s2ck_pkg::RECIP_6)) >> s2ck_pkg::SH_6);
            qc7_reg <= 30'((62'(pc6_reg) * 62'(s2ck_pkg::RECIP_12)) >> s2ck_pkg::SH_12);
            sn8_reg <= 30'((61'(x_reg[7]) * 61'(s2ck_pkg::ONE_Q30 - 31'(qs7_reg)))
                           >> s2ck_pkg::TRIG_FRAC);
            pc8_reg <= 30'((61'(xx_reg[7]) * 61'(s2ck_pkg::ONE_Q30 - 31'(qc7_reg)))
                           >> s2ck_pkg::TRIG_FRAC);

            // quadrant mapping
            case (quad_reg[7])
                s2ck_pkg::QUAD_I:
                begin
                    sin_reg <= s0;
                    cos_reg <= c0;
                end
                s2ck_pkg::QUAD_II:
                begin
                    sin_reg <= c0;
                    cos_reg <= -s0;
                end
                s2ck_pkg::QUAD_III:
                begin
                    sin_reg <= -s0;
                    cos_reg <= -c0;
                end
                default:
                begin
                    sin_reg <= -c0;
                    cos_reg <= s0;
                end
            endcase
        end
    end

    assign sin_q = sin_reg;
    assign cos_q = cos_reg;

endmodule

/* sv/s2ck_back.sv */
// back end: trig units and the kinematics pipeline up to the result register
`timescale 1ns / 1ps

module s2ck_back #(
    parameter int FRAC_BITS = s2ck_pkg::FRAC_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 pop_valid,
    output logic                 pop_ready,
    input  s2ck_pkg::s2ck_work_t pop_data,
    output logic                 cart_valid,
    input  logic                 cart_ready,
    output s2ck_pkg::s2ck_cart_t cart
);

    // work register, nine trig stages, twelve kinematics stages
    localparam int NSTAGE = 22;

    logic [NSTAGE-1:0]     vld_reg;
    logic [NSTAGE-1:0]     vld_next;
    logic                  en;

    s2ck_pkg::s2ck_work_t  w_reg;
    s2ck_pkg::s2ck_rates_t rt_reg [1:9];
    s2ck_pkg::s2ck_trig_t  tr_reg [1:9];
    s2ck_pkg::s2ck_trig_t  trig;
    s2ck_pkg::s2ck_cart_t  part_reg [4:11];
    s2ck_pkg::s2ck_cart_t  out_reg;

    logic signed [63:0] m1_rsz, m1_z, m1_rds, m1_rdc, m1_rzed, m1_razd;
    logic signed [63:0] m1_rdzed, m1_rzedd, m1_rdazd, m1_razdd;
    logic signed [31:0] zed1, azd1, rdd1;
    logic signed [31:0] rsz2, z2, rds2, rdc2, rzed2, razd2, a2, b2, c2, d2;
    logic signed [31:0] zed2, azd2, rdd2;
    logic signed [63:0] m3_zzed, m3_tang, m3_rzeds, m3_razdsq, m3_rzedsq, m3_razdzed;
    logic signed [63:0] m3_px, m3_py;
    logic signed [31:0] zterm3, azsum3, z3, rds3, rdc3, rdd3;
    logic signed [31:0] zzed4, tang4, rzeds4, razdsq4, rzedsq4, razdzed4;
    logic signed [31:0] zterm4, azsum4, rds4, rdc4, rdd4;
    logic signed [31:0] radial5, m5, e5, tang5, rzedsq5, razdzed5, zterm5, azsum5;
    logic signed [31:0] inarg6, radial6, tang6, e6, razdzed6, zterm6, azsum6;
    logic signed [63:0] m7_v1, m7_v2, m7_v3, m7_v4, m7_inpl, m7_zc, m7_azt;
    logic signed [63:0] m7_cross, m7_ec, m7_zs;
    logic signed [31:0] v1_8, v2_8, v3_8, v4_8, inpl8, zc8, azt8, cross8, ec8, zs8;
    logic signed [31:0] p9, q9;
    logic signed [63:0] m10_a, m10_b, m10_c, m10_d;
    logic signed [31:0] a11, b11, c11, d11;

    // clip to the signed 32 bit range
    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647)
            return 32'sh7FFF_FFFF;
        else if (v < -64'sd2147483648)
            return 32'sh8000_0000;
        else
            return 32'(v);
    endfunction

    // round to nearest, ties up, then clip
    function automatic logic signed [31:0] rnd(input logic signed [63:0] prod,
                                               input int sh);
        logic signed [63:0] bias;
        bias = 64'sd1 <<< (sh - 1);
        return sat32((prod + bias) >>> sh);
    endfunction

    function automatic logic signed [31:0] sadd(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
        return sat32(64'(a) + 64'(b));
    endfunction

    function automatic logic signed [31:0] ssub(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
        return sat32(64'(a) - 64'(b));
    endfunction

    function automatic logic signed [31:0] sdbl(input logic signed [31:0] a);
        return sat32(64'(a) + 64'(a));
    endfunction

    function automatic logic signed [63:0] smul(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
        return 64'(a) * 64'(b);
    endfunction

    // whole pipeline advances unless the result register is held
    assign en        = !vld_reg[NSTAGE-1] || cart_ready;
    assign pop_ready = en;
    assign vld_next  = {vld_reg[NSTAGE-2:0], pop_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= vld_next;
    end

    // sine and cosine of both angles
    s2ck_trig u_trig_az (
        .clk   (clk),
        .en    (en),
        .oct   (w_reg.az),
        .sin_q (trig.sin_az),
        .cos_q (trig.cos_az)
    );

    s2ck_trig u_trig_ze (
        .clk   (clk),
        .en    (en),
        .oct   (w_reg.ze),
        .sin_q (trig.sin_ze),
        .cos_q (trig.cos_ze)
    );

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // work register and rate delay line beside the trig units
            w_reg     <= pop_data;
            rt_reg[1] <= w_reg.rates;
            for (int i = 2; i <= 9; i++)
                rt_reg[i] <= rt_reg[i-1];
            tr_reg[1] <= trig;
            for (int i = 2; i <= 9; i++)
                tr_reg[i] <= tr_reg[i-1];

            // first products
            m1_rsz   <= smul(rt_reg[9].range_len, trig.sin_ze);
            m1_z     <= smul(rt_reg[9].range_len, trig.cos_ze);
            m1_rds   <= smul(rt_reg[9].range_rate, trig.sin_ze);
            m1_rdc   <= smul(rt_reg[9].range_rate, trig.cos_ze);
            m1_rzed  <= smul(rt_reg[9].range_len, rt_reg[9].zenith_rate);
            m1_razd  <= smul(rt_reg[9].range_len, rt_reg[9].azimuth_rate);
            m1_rdzed <= smul(rt_reg[9].range_rate, rt_reg[9].zenith_rate);
            m1_rzedd <= smul(rt_reg[9].range_len, rt_reg[9].zenith_accel);
            m1_rdazd <= smul(rt_reg[9].range_rate, rt_reg[9].azimuth_rate);
            m1_razdd <= smul(rt_reg[9].range_len, rt_reg[9].azimuth_accel);
            zed1     <= rt_reg[9].zenith_rate;
            azd1     <= rt_reg[9].azimuth_rate;
            rdd1     <= rt_reg[9].range_accel;

            // round first products
            rsz2  <= rnd(m1_rsz, s2ck_pkg::TRIG_FRAC);
            z2    <= rnd(m1_z, s2ck_pkg::TRIG_FRAC);
            rds2  <= rnd(m1_rds, s2ck_pkg::TRIG_FRAC);
            rdc2  <= rnd(m1_rdc, s2ck_pkg::TRIG_FRAC);
            rzed2 <= rnd(m1_rzed, FRAC_BITS);
            razd2 <= rnd(m1_razd, FRAC_BITS);
            a2    <= sdbl(rnd(m1_rdzed, FRAC_BITS));
            b2    <= rnd(m1_rzedd, FRAC_BITS);
            c2    <= sdbl(rnd(m1_rdazd, FRAC_BITS));
            d2    <= rnd(m1_razdd, FRAC_BITS);
            zed2  <= zed1;
            azd2  <= azd1;
            rdd2  <= rdd1;

            // second products, zenith and azimuth terms
            m3_zzed    <= smul(z2, zed2);
            m3_tang    <= smul(rsz2, azd2);
            m3_rzeds   <= smul(rzed2, tr_reg[2].sin_ze);
            m3_razdsq  <= smul(razd2, azd2);
            m3_rzedsq  <= smul(rzed2, zed2);
            m3_razdzed <= smul(razd2, zed2);
            m3_px      <= smul(rsz2, tr_reg[2].cos_az);
            m3_py      <= smul(rsz2, tr_reg[2].sin_az);
            zterm3     <= sadd(a2, b2);
            azsum3     <= sadd(c2, d2);
            z3         <= z2;
            rds3       <= rds2;
            rdc3       <= rdc2;
            rdd3       <= rdd2;

            // round second products, position is complete here
            zzed4    <= rnd(m3_zzed, FRAC_BITS);
            tang4    <= rnd(m3_tang, FRAC_BITS);
            rzeds4   <= rnd(m3_rzeds, s2ck_pkg::TRIG_FRAC);
            razdsq4  <= rnd(m3_razdsq, FRAC_BITS);
            rzedsq4  <= rnd(m3_rzedsq, FRAC_BITS);
            razdzed4 <= rnd(m3_razdzed, FRAC_BITS);
            part_reg[4] <= '{pos_x: rnd(m3_px, s2ck_pkg::TRIG_FRAC),
                             pos_y: rnd(m3_py, s2ck_pkg::TRIG_FRAC),
                             pos_z: z3,
                             vel_x: 32'sd0,
                             vel_y: 32'sd0,
                             vel_z: 32'sd0,
                             acc_x: 32'sd0,
                             acc_y: 32'sd0,
                             acc_z: 32'sd0};
            zterm4   <= zterm3;
            azsum4   <= azsum3;
            rds4     <= rds3;
            rdc4     <= rdc3;
            rdd4     <= rdd3;

            // radial sum, z velocity and in-plane differences
            radial5  <= sadd(rds4, zzed4);
            m5       <= ssub(rdd4, razdsq4);
            e5       <= ssub(rdd4, rzedsq4);
            tang5    <= tang4;
            rzedsq5  <= rzedsq4;
            razdzed5 <= razdzed4;
            zterm5   <= zterm4;
            azsum5   <= azsum4;
            part_reg[5] <= '{pos_x: part_reg[4].pos_x,
                             pos_y: part_reg[4].pos_y,
                             pos_z: part_reg[4].pos_z,
                             vel_x: part_reg[4].vel_x,
                             vel_y: part_reg[4].vel_y,
                             vel_z: ssub(rdc4, rzeds4),
                             acc_x: part_reg[4].acc_x,
                             acc_y: part_reg[4].acc_y,
                             acc_z: part_reg[4].acc_z};

            // finish the in-plane argument
            inarg6   <= ssub(m5, rzedsq5);
            radial6  <= radial5;
            tang6    <= tang5;
            e6       <= e5;
            razdzed6 <= razdzed5;
            zterm6   <= zterm5;
            azsum6   <= azsum5;
            part_reg[6] <= part_reg[5];

            // third products against the trig values
            m7_v1    <= smul(radial6, tr_reg[6].cos_az);
            m7_v2    <= smul(tang6, tr_reg[6].sin_az);
            m7_v3    <= smul(radial6, tr_reg[6].sin_az);
            m7_v4    <= smul(tang6, tr_reg[6].cos_az);
            m7_inpl  <= smul(inarg6, tr_reg[6].sin_ze);
            m7_zc    <= smul(zterm6, tr_reg[6].cos_ze);
            m7_azt   <= smul(azsum6, tr_reg[6].sin_ze);
            m7_cross <= smul(razdzed6, tr_reg[6].cos_ze);
            m7_ec    <= smul(e6, tr_reg[6].cos_ze);
            m7_zs    <= smul(zterm6, tr_reg[6].sin_ze);
            part_reg[7] <= part_reg[6];

            // round third products
            v1_8   <= rnd(m7_v1, s2ck_pkg::TRIG_FRAC);
            v2_8   <= rnd(m7_v2, s2ck_pkg::TRIG_FRAC);
            v3_8   <= rnd(m7_v3, s2ck_pkg::TRIG_FRAC);
            v4_8   <= rnd(m7_v4, s2ck_pkg::TRIG_FRAC);
            inpl8  <= rnd(m7_inpl, s2ck_pkg::TRIG_FRAC);
            zc8    <= rnd(m7_zc, s2ck_pkg::TRIG_FRAC);
            azt8   <= rnd(m7_azt, s2ck_pkg::TRIG_FRAC);
            cross8 <= sdbl(rnd(m7_cross, s2ck_pkg::TRIG_FRAC));
            ec8    <= rnd(m7_ec, s2ck_pkg::TRIG_FRAC);
            zs8    <= rnd(m7_zs, s2ck_pkg::TRIG_FRAC);
            part_reg[8] <= part_reg[7];

            // velocity complete, acceleration terms combined
            p9 <= sadd(inpl8, zc8);
            q9 <= sadd(azt8, cross8);
            part_reg[9] <= '{pos_x: part_reg[8].pos_x,
                             pos_y: part_reg[8].pos_y,
                             pos_z: part_reg[8].pos_z,
                             vel_x: ssub(v1_8, v2_8),
                             vel_y: sadd(v3_8, v4_8),
                             vel_z: part_reg[8].vel_z,
                             acc_x: part_reg[8].acc_x,
                             acc_y: part_reg[8].acc_y,
                             acc_z: ssub(ec8, zs8)};

            // last products, azimuth rotation of the acceleration
            m10_a <= smul(p9, tr_reg[9].cos_az);
            m10_b <= smul(q9, tr_reg[9].sin_az);
            m10_c <= smul(p9, tr_reg[9].sin_az);
            m10_d <= smul(q9, tr_reg[9].cos_az);
            part_reg[10] <= part_reg[9];

            a11 <= rnd(m10_a, s2ck_pkg::TRIG_FRAC);
            b11 <= rnd(m10_b, s2ck_pkg::TRIG_FRAC);
            c11 <= rnd(m10_c, s2ck_pkg::TRIG_FRAC);
            d11 <= rnd(m10_d, s2ck_pkg::TRIG_FRAC);
            part_reg[11] <= part_reg[10];

            // result register
            out_reg <= '{pos_x: part_reg[11].pos_x,
                         pos_y: part_reg[11].pos_y,
                         pos_z: part_reg[11].pos_z,
                         vel_x: part_reg[11].vel_x,
                         vel_y: part_reg[11].vel_y,
                         vel_z: part_reg[11].vel_z,
                         acc_x: ssub(a11, b11),
                         acc_y: sadd(c11, d11),
                         acc_z: part_reg[11].acc_z};
        end
    end

    assign cart_valid = vld_reg[NSTAGE-1];
    assign cart       = out_reg;

`ifndef SYNTHESIS
    a_stall_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg[NSTAGE-1] && !cart_ready) |=> $stable(vld_reg))
        else $error("pipeline moved while the result was held");
`endif

endmodule

/* sv/spherical_to_cartesian_kinematics_core.sv */
// top level of the spherical to cartesian kinematics core
`timescale 1ns / 1ps

// Converts one spherical track state per item (azimuth, zenith, range and
// their first and second derivatives) into Cartesian position, velocity and
// acceleration, all signed Q16.16 and clipped to 32 bits.
// Input channel track_valid/track_ready carries the track item; output
// channel cart_valid/cart_ready carries the result item. One result per item,
// in order.
// Throughput: one item per cycle while the back is not held. The front
// register classifies the angles, a four entry queue decouples it from the
// back, and the back is a 22 stage pipeline (work register, nine stage trig
// unit, twelve kinematics stages); items pass them in order to cart_valid.
// When cart_ready is low with a result waiting, the back pipeline holds;
// the queue keeps taking items until full, then track_ready drops.
// Reset clears the valid bits and the queue; no item is lost or repeated
// across a stall. No state carries from one item to the next.
module spherical_to_cartesian_kinematics_core #(
    parameter int ANGLE_BITS = s2ck_pkg::ANGLE_BITS_DEF,
    parameter int FRAC_BITS  = s2ck_pkg::FRAC_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  track_valid,
    output logic                  track_ready,
    input  s2ck_pkg::s2ck_track_t track,
    output logic                  cart_valid,
    input  logic                  cart_ready,
    output s2ck_pkg::s2ck_cart_t  cart
);

    logic                 push_valid;
    logic                 push_ready;
    s2ck_pkg::s2ck_work_t push_data;
    logic                 pop_valid;
    logic                 pop_ready;
    s2ck_pkg::s2ck_work_t pop_data;

    // angle classification
    s2ck_front #(
        .ANGLE_BITS (ANGLE_BITS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .track_valid (track_valid),
        .track_ready (track_ready),
        .track       (track),
        .push_valid  (push_valid),
        .push_ready  (push_ready),
        .push_data   (push_data)
    );

    // decoupling queue
    s2ck_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    // trig and kinematics
    s2ck_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data),
        .cart_valid (cart_valid),
        .cart_ready (cart_ready),
        .cart       (cart)
    );

endmodule
